>>> hw/rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

  localparam int unsigned POS_W     = 7;
  localparam int unsigned IN_ID_W   = 16;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned TDATA_W   = 32;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_DELETE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic eval;
    logic rd;
    logic wr_shift;
    logic wr_id;
    logic cnt_inc;
    logic cnt_dec;
    logic res_load;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  ok;
    logic  no_shift;
    logic  last_rd;
  } dp_stat_t;

endpackage

>>> hw/rtl/ple_datapath.sv
// Datapath of the positional list engine: entry memory, count, pointers and result register.
`timescale 1ns / 1ps

module ple_datapath #(
  parameter int unsigned DEPTH    = 64,
  parameter int unsigned ID_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ple_pkg::dp_cmd_t                   cmd_i,
  output ple_pkg::dp_stat_t                  stat_o,
  input  ple_pkg::mode_e                     mode_i,
  input  logic [ple_pkg::POS_W-1:0]          pos_i,
  input  logic [ple_pkg::IN_ID_W-1:0]        id_i,
  output ple_pkg::status_e                   status_o,
  output logic [ple_pkg::IN_ID_W-1:0]        found_o,
  output logic [ple_pkg::CNT_OUT_W-1:0]      count_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

  logic [ID_WIDTH-1:0]       mem [DEPTH];
  logic [ID_WIDTH-1:0]       rd_q;
  logic [ID_WIDTH-1:0]       id_q;
  ple_pkg::mode_e            mode_q;
  logic [ple_pkg::POS_W-1:0] pos_q;
  ple_pkg::status_e          code_q;
  ple_pkg::status_e          code_d;
  logic [CW-1:0]             count_q;
  logic [CW-1:0]             count_d;
  logic [AW-1:0]             ptr_q;
  logic [AW-1:0]             ptr_d;
  logic [AW-1:0]             wa_q;
  logic [CMPW-1:0]           pos_x;
  logic [CMPW-1:0]           cnt_x;
  logic [AW-1:0]             pos_idx;
  logic [AW-1:0]             cnt_last;
  logic [AW-1:0]             id_addr;
  logic                      full;
  logic                      empty;
  logic                      pos_zero;
  logic                      no_shift;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [ID_WIDTH-1:0]       wr_data;
  ple_pkg::status_e          res_status_q;
  logic [ple_pkg::IN_ID_W-1:0]   res_found_q;
  logic [ple_pkg::CNT_OUT_W-1:0] res_count_q;

  assign pos_x    = CMPW'(pos_q);
  assign cnt_x    = CMPW'(count_q);
  assign pos_idx  = AW'(pos_x - CMPW'(1));
  assign cnt_last = AW'(count_q - CW'(1));
  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign pos_zero = (pos_q == '0);
  assign id_addr  = (mode_q == ple_pkg::MODE_APPEND) ? AW'(count_q) : pos_idx;

  always_comb begin
    code_d   = ple_pkg::ST_OK;
    no_shift = 1'b0;
    case (mode_q)
      ple_pkg::MODE_APPEND: begin
        code_d   = full ? ple_pkg::ST_FULL : ple_pkg::ST_OK;
        no_shift = 1'b1;
      end
      ple_pkg::MODE_INSERT: begin
        if (pos_zero || (pos_x > cnt_x + CMPW'(1))) begin
          code_d = ple_pkg::ST_BADPOS;
        end else if (full) begin
          code_d = ple_pkg::ST_FULL;
        end
        no_shift = (pos_x == cnt_x + CMPW'(1));
      end
      ple_pkg::MODE_LOOKUP, ple_pkg::MODE_DELETE: begin
        if (empty) begin
          code_d = ple_pkg::ST_EMPTY;
        end else if (pos_zero || (pos_x > cnt_x)) begin
          code_d = ple_pkg::ST_BADPOS;
        end
        no_shift = (pos_x == cnt_x);
      end
      default: begin
        code_d = ple_pkg::ST_OK;
      end
    endcase
  end

  assign stat_o.no_shift = no_shift;
  assign stat_o.mode     = mode_q;
  assign stat_o.ok       = (code_d == ple_pkg::ST_OK);
  assign stat_o.last_rd  = (mode_q == ple_pkg::MODE_INSERT) ? (ptr_q == pos_idx)
                                                            : (ptr_q == cnt_last);

  always_comb begin
    case (mode_q)
      ple_pkg::MODE_INSERT: ptr_d = cnt_last;
      ple_pkg::MODE_DELETE: ptr_d = AW'(pos_x);
      default:              ptr_d = pos_idx;
    endcase
    if (cmd_i.rd) begin
      ptr_d = (mode_q == ple_pkg::MODE_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
    end else if (!cmd_i.eval) begin
      ptr_d = ptr_q;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      pos_q  <= pos_i;
      id_q   <= ID_WIDTH'(id_i);
    end
    if (cmd_i.eval) begin
      code_q <= code_d;
    end
    ptr_q <= ptr_d;
    if (cmd_i.rd) begin
      wa_q <= (mode_q == ple_pkg::MODE_INSERT) ? ptr_q + AW'(1) : ptr_q - AW'(1);
    end
    if (cmd_i.res_load) begin
      res_status_q <= code_q;
      res_found_q  <= ((mode_q == ple_pkg::MODE_LOOKUP) && (code_q == ple_pkg::ST_OK))
                      ? ple_pkg::IN_ID_W'(rd_q) : '0;
      res_count_q  <= ple_pkg::CNT_OUT_W'(count_q);
    end
  end

  assign wr_en   = cmd_i.wr_shift || cmd_i.wr_id;
  assign wr_addr = cmd_i.wr_shift ? wa_q : id_addr;
  assign wr_data = cmd_i.wr_shift ? rd_q : id_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[ptr_q];
    end
  end

  assign status_o = res_status_q;
  assign found_o  = res_found_q;
  assign count_o  = res_count_q;

`ifndef SYNTHESIS
  a_cnt_inc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |=> count_q == $past(count_q) + CW'(1))
    else $error("count did not advance by one on an insert");
  a_no_inc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> count_q != CW'(DEPTH))
    else $error("entry added to a full store");
  a_no_dec_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> count_q != '0)
    else $error("entry removed from an empty store");
`endif

endmodule

>>> hw/rtl/ple_ctrl.sv
// Controller state machine of the positional list engine.
`timescale 1ns / 1ps

module ple_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ple_pkg::dp_stat_t  stat_i,
  output ple_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EVAL  = 8'b0000_0010,
    S_LOOK  = 8'b0000_0100,
    S_PRIME = 8'b0000_1000,
    S_SHIFT = 8'b0001_0000,
    S_DRAIN = 8'b0010_0000,
    S_PUT   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (!stat_i.ok) begin
          state_d = S_DONE;
        end else begin
          case (stat_i.mode)
            ple_pkg::MODE_LOOKUP: state_d = S_LOOK;
            ple_pkg::MODE_APPEND: state_d = S_PUT;
            ple_pkg::MODE_INSERT: state_d = stat_i.no_shift ? S_PUT : S_PRIME;
            ple_pkg::MODE_DELETE: begin
              if (stat_i.no_shift) begin
                cmd_o.cnt_dec = 1'b1;
                state_d       = S_DONE;
              end else begin
                state_d = S_PRIME;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_LOOK: begin
        cmd_o.rd = 1'b1;
        state_d  = S_DONE;
      end
      S_PRIME: begin
        cmd_o.rd = 1'b1;
        state_d  = stat_i.last_rd ? S_DRAIN : S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.rd       = 1'b1;
        cmd_o.wr_shift = 1'b1;
        if (stat_i.last_rd) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd_o.wr_shift = 1'b1;
        if (stat_i.mode == ple_pkg::MODE_INSERT) begin
          state_d = S_PUT;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_PUT: begin
        cmd_o.wr_id   = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_res_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_shift |-> !cmd_o.wr_id)
    else $error("two writes to the entry memory in one cycle");
`endif

endmodule

>>> hw/rtl/positional_list_engine_unit.sv
// Top level of the positional list engine: stream ports around controller and datapath.
// A rejected command or a delete of the last entry goes from evaluation straight to the
// result; append, lookup and insert at the end make one memory access; a delete or insert
// moves its entries first. The next word is taken in the cycle after the result loads.
// One command at a time: the entry memory moves one entry per cycle through its read port.
// Reset is asynchronous and active low; it empties the list but leaves memory contents as is.
`timescale 1ns / 1ps

module positional_list_engine_unit #(
  parameter int unsigned DEPTH    = 64,
  parameter int unsigned ID_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // mode [1:0], position [8:2], item_id [24:9], zero fill above
  input  logic [ple_pkg::TDATA_W-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status [1:0], found_id [17:2], item_count [24:18], zero fill above
  output logic [ple_pkg::TDATA_W-1:0]   m_axis_tdata
);

  ple_pkg::dp_cmd_t              cmd;
  ple_pkg::dp_stat_t             stat;
  ple_pkg::mode_e                mode;
  ple_pkg::status_e              status;
  logic [ple_pkg::IN_ID_W-1:0]   found_id;
  logic [ple_pkg::CNT_OUT_W-1:0] item_count;

  assign mode = ple_pkg::mode_e'(s_axis_tdata[1:0]);

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ple_datapath #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .mode_i   (mode),
    .pos_i    (s_axis_tdata[8:2]),
    .id_i     (s_axis_tdata[24:9]),
    .status_o (status),
    .found_o  (found_id),
    .count_o  (item_count)
  );

  assign m_axis_tdata = ple_pkg::TDATA_W'({item_count, found_id, status});

endmodule

>>> tb/sv/positional_list_engine_unit_checker.sv
// Result checker for the positional list engine: tracks the list and compares every result word.
`timescale 1ns / 1ps

module positional_list_engine_unit_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [ple_pkg::TDATA_W-1:0] s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [ple_pkg::TDATA_W-1:0] m_axis_tdata,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o,
  output int unsigned                 checked_o
);

  typedef struct packed {
    ple_pkg::status_e status;
    logic [15:0]      found_id;
    logic [6:0]       item_count;
  } list_reply_t;

  logic [15:0]  list_mem [DEPTH];
  int unsigned  list_len;
  list_reply_t  reply_q [$];

  function automatic list_reply_t run_list_command(ple_pkg::mode_e op, int unsigned pos,
                                                   logic [15:0] id);
    list_reply_t r;
    int unsigned i;
    r.status   = ple_pkg::ST_OK;
    r.found_id = '0;
    case (op)
      ple_pkg::MODE_APPEND: begin
        if (list_len >= DEPTH) begin
          r.status = ple_pkg::ST_FULL;
        end else begin
          list_mem[list_len] = id;
          list_len++;
        end
      end
      ple_pkg::MODE_INSERT: begin
        if (pos == 0 || pos > list_len + 1) begin
          r.status = ple_pkg::ST_BADPOS;
        end else if (list_len >= DEPTH) begin
          r.status = ple_pkg::ST_FULL;
        end else begin
          for (i = list_len; i > pos - 1; i--) list_mem[i] = list_mem[i - 1];
          list_mem[pos - 1] = id;
          list_len++;
        end
      end
      ple_pkg::MODE_LOOKUP: begin
        if (list_len == 0) begin
          r.status = ple_pkg::ST_EMPTY;
        end else if (pos == 0 || pos > list_len) begin
          r.status = ple_pkg::ST_BADPOS;
        end else begin
          r.found_id = list_mem[pos - 1];
        end
      end
      default: begin
        if (list_len == 0) begin
          r.status = ple_pkg::ST_EMPTY;
        end else if (pos == 0 || pos > list_len) begin
          r.status = ple_pkg::ST_BADPOS;
        end else begin
          for (i = pos - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
    endcase
    r.item_count = 7'(list_len);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t want;
    list_reply_t got;
    if (!rst_ni) begin
      reply_q.delete();
      list_len  = 0;
      pending_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        reply_q.push_back(run_list_command(ple_pkg::mode_e'(s_axis_tdata[1:0]),
                                           s_axis_tdata[8:2], s_axis_tdata[24:9]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status     = ple_pkg::status_e'(m_axis_tdata[1:0]);
        got.found_id   = m_axis_tdata[17:2];
        got.item_count = m_axis_tdata[24:18];
        if (reply_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("Unexpected result word: status %0d id %h count %0d",
                     got.status, got.found_id, got.item_count);
          end
        end else begin
          want = reply_q.pop_front();
          if (got.status != want.status || got.found_id != want.found_id ||
              got.item_count != want.item_count) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("Mismatch on result %0d: expected status %0d id %h count %0d, got %s",
                       checked_o, want.status, want.found_id, want.item_count,
                       $sformatf("status %0d id %h count %0d",
                                 got.status, got.found_id, got.item_count));
            end
          end
        end
        checked_o++;
      end
      pending_o = reply_q.size();
    end
  end

endmodule

>>> tb/sv/positional_list_engine_unit_tb.sv
// Testbench top for the positional list engine: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module positional_list_engine_unit_tb;

  localparam int unsigned DEPTH = 64;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [ple_pkg::TDATA_W-1:0] s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [ple_pkg::TDATA_W-1:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  int unsigned stim_len = 0;
  int unsigned words_sent = 0;
  int unsigned full_hits = 0;
  int unsigned empty_hits = 0;
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b0;
  int unsigned sink_stall = 0;
  int unsigned sink_mode_left = 200;

  positional_list_engine_unit #(
    .DEPTH   (DEPTH),
    .ID_WIDTH(16)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  positional_list_engine_unit_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAIL positional_list_engine_unit");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (sink_mode_left == 0) begin
        sink_calm      <= ($urandom_range(0, 3) == 0);
        sink_mode_left <= $urandom_range(100, 400);
      end else begin
        sink_mode_left <= sink_mode_left - 1;
      end
      if (sink_stall > 0) begin
        m_axis_tready <= 1'b0;
        sink_stall    <= sink_stall - 1;
      end else if (!sink_calm && $urandom_range(0, 99) < 25) begin
        m_axis_tready <= 1'b0;
        sink_stall    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                     : $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (src_calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [6:0] pick_position(ple_pkg::mode_e op);
    int unsigned top_pos;
    int unsigned r;
    top_pos = (op == ple_pkg::MODE_INSERT) ? stim_len + 1 : stim_len;
    if (op == ple_pkg::MODE_APPEND) return 7'($urandom_range(0, 127));
    if (top_pos == 0 || $urandom_range(0, 99) < 18) begin
      r = $urandom_range(0, 2);
      if (r == 0) return 7'd0;
      if (r == 1) return 7'(top_pos + 1);
      return 7'($urandom_range(0, 127));
    end
    r = $urandom_range(0, 9);
    if (r < 2) return 7'd1;
    if (r < 4) return 7'(top_pos);
    return 7'($urandom_range(1, top_pos));
  endfunction

  // The gap before a word is taken here, so tvalid is only lowered when a gap follows.
  task automatic send_cmd(ple_pkg::mode_e op, logic [6:0] pos, logic [15:0] id);
    int unsigned gap;
    int unsigned old_len;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {7'b0, id, pos, op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
    old_len = stim_len;
    case (op)
      ple_pkg::MODE_APPEND: if (stim_len < DEPTH) stim_len++;
      ple_pkg::MODE_INSERT:
        if (pos != 0 && pos <= stim_len + 1 && stim_len < DEPTH) stim_len++;
      ple_pkg::MODE_DELETE: if (pos != 0 && pos <= stim_len) stim_len--;
      default: ;
    endcase
    if (old_len != stim_len && stim_len == DEPTH) full_hits++;
    if (old_len != stim_len && stim_len == 0) empty_hits++;
  endtask

  initial begin
    bit             growing;
    int unsigned    shrink_to;
    int unsigned    r;
    int unsigned    guard;
    ple_pkg::mode_e op;
    logic [15:0]    id;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(ple_pkg::MODE_LOOKUP, 7'd1, 16'h0000);
    send_cmd(ple_pkg::MODE_DELETE, 7'd127, 16'h0000);
    send_cmd(ple_pkg::MODE_INSERT, 7'd0, 16'h1234);
    send_cmd(ple_pkg::MODE_INSERT, 7'd2, 16'h1234);
    send_cmd(ple_pkg::MODE_INSERT, 7'd1, 16'hFFFF);
    send_cmd(ple_pkg::MODE_APPEND, 7'd0, 16'h0000);
    send_cmd(ple_pkg::MODE_APPEND, 7'd127, 16'h5A5A);
    send_cmd(ple_pkg::MODE_INSERT, 7'd4, 16'h0001);
    send_cmd(ple_pkg::MODE_INSERT, 7'd6, 16'h0002);
    send_cmd(ple_pkg::MODE_INSERT, 7'd1, 16'h8000);
    send_cmd(ple_pkg::MODE_INSERT, 7'd3, 16'h7FFF);
    send_cmd(ple_pkg::MODE_LOOKUP, 7'd0, 16'h0000);
    send_cmd(ple_pkg::MODE_LOOKUP, 7'd6, 16'h0000);
    send_cmd(ple_pkg::MODE_LOOKUP, 7'd7, 16'h0000);
    send_cmd(ple_pkg::MODE_LOOKUP, 7'd127, 16'hFFFF);
    send_cmd(ple_pkg::MODE_LOOKUP, 7'd1, 16'h0000);
    send_cmd(ple_pkg::MODE_DELETE, 7'd1, 16'h0000);
    send_cmd(ple_pkg::MODE_DELETE, 7'd5, 16'h0000);
    send_cmd(ple_pkg::MODE_DELETE, 7'd0, 16'h0000);
    send_cmd(ple_pkg::MODE_DELETE, 7'd5, 16'h0000);
    send_cmd(ple_pkg::MODE_DELETE, 7'd2, 16'h0000);
    send_cmd(ple_pkg::MODE_LOOKUP, 7'd2, 16'hFFFF);

    // Fill the list to full, dwell there, then drain it part way or to empty.
    growing   = 1'b1;
    shrink_to = 0;
    repeat (1128) begin
      if ($urandom_range(0, 99) == 0) src_calm = ~src_calm;
      if (growing && stim_len == DEPTH && $urandom_range(0, 7) == 0) begin
        growing   = 1'b0;
        shrink_to = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 40);
      end else if (!growing && stim_len <= shrink_to && $urandom_range(0, 3) == 0) begin
        growing = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (growing) begin
        op = (r < 40) ? ple_pkg::MODE_APPEND : (r < 75) ? ple_pkg::MODE_INSERT :
             (r < 90) ? ple_pkg::MODE_LOOKUP : ple_pkg::MODE_DELETE;
      end else begin
        op = (r < 55) ? ple_pkg::MODE_DELETE : (r < 75) ? ple_pkg::MODE_LOOKUP :
             (r < 85) ? ple_pkg::MODE_APPEND : ple_pkg::MODE_INSERT;
      end
      r  = $urandom_range(0, 19);
      id = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      send_cmd(op, pick_position(op), id);
    end
    s_axis_tvalid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);

    $display("Sent %0d command words; the list filled up %0d times and emptied %0d times.",
             words_sent, full_hits, empty_hits);
    $display("Checked %0d result words, %0d still outstanding.", checked, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS positional_list_engine_unit");
    end else begin
      $display("FAIL positional_list_engine_unit");
    end
    $finish;
  end

endmodule
